// ----- rtl/core/mtep_pkg.sv -----
// Package of types and constants shared by the MIDI track event parser.
`default_nettype none

package mtep_pkg;

   localparam int TICK_BITS       = 32;
   localparam int EVENT_TICK_BITS = 32;
   localparam int VARLEN_BITS     = 28;
   localparam int TEMPO_BITS      = 24;
   localparam int CSR_DATA_BITS   = 16;
   localparam int RSP_DEPTH       = 4;
   localparam int RSP_PTR_BITS    = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS    = $clog2(RSP_DEPTH + 1);

   localparam logic [7:0] STATUS_FLAG      = 8'h80;
   localparam logic [7:0] STATUS_META      = 8'hff;
   localparam logic [7:0] STATUS_SYSEX_MIN = 8'hf0;
   localparam logic [7:0] META_TEMPO       = 8'h51;
   localparam logic [7:0] CTL_SUSTAIN      = 8'd64;
   localparam logic [7:0] CTL_SOSTENUTO    = 8'd66;
   localparam logic [7:0] CTL_SOFT         = 8'd67;

   localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
   localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
   localparam logic [3:0] MSG_CONTROL  = 4'hb;
   localparam logic [3:0] MSG_PROGRAM  = 4'hc;
   localparam logic [3:0] MSG_PRESSURE = 4'hd;

   localparam logic [1:0] VARLEN_LAST_COUNT = 2'd3;
   localparam logic [1:0] TEMPO_FULL_BYTES  = 2'd3;

   typedef logic [TICK_BITS-1:0]       tick_type;
   typedef logic [EVENT_TICK_BITS-1:0] event_ticks_type;
   typedef logic [VARLEN_BITS-1:0]     varlen_type;
   typedef logic [TEMPO_BITS-1:0]      tempo_type;

   typedef enum logic [0:0] {
      REG_CHANNEL_MASK = 1'b0,
      REG_PERCUSSION   = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      EV_PLAY   = 3'd0,
      EV_STOP   = 3'd1,
      EV_TEMPO  = 3'd2,
      EV_PEDAL0 = 3'd3,
      EV_PEDAL1 = 3'd4,
      EV_PEDAL2 = 3'd5,
      EV_DONE   = 3'd6,
      EV_ERROR  = 3'd7
   } event_kind_type;

   typedef enum logic [8:0] {
      PH_DELTA     = 9'b000000001,
      PH_STATUS    = 9'b000000010,
      PH_DATA1     = 9'b000000100,
      PH_DATA2     = 9'b000001000,
      PH_META_TYPE = 9'b000010000,
      PH_META_LEN  = 9'b000100000,
      PH_META_DATA = 9'b001000000,
      PH_SYSEX_LEN = 9'b010000000,
      PH_SKIP      = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [15:0] channel_enable_mask;
      logic [3:0]  percussion_channel;
   } cfg_type;

   typedef struct packed {
      event_kind_type  event_kind;
      logic [7:0]      note_number;
      logic [7:0]      level;
      tempo_type       tempo_value;
      event_ticks_type event_ticks;
      logic            last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

`default_nettype wire

// ----- rtl/core/mtep_req_if.sv -----
// Request channel carrying one track byte per transaction.
`default_nettype none

interface mtep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_track;

   modport source(output valid, data_byte, end_of_track, input ready);
   modport sink(input valid, data_byte, end_of_track, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mtep_rsp_if.sv -----
// Response channel carrying one parsed event per transaction.
`default_nettype none

interface mtep_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [7:0]  note_number;
   logic [7:0]  level;
   logic [23:0] tempo_value;
   logic [31:0] event_ticks;
   logic        last_of_run;

   modport source(output valid, event_kind, note_number, level, tempo_value, event_ticks,
                  last_of_run, input ready);
   modport sink(input valid, event_kind, note_number, level, tempo_value, event_ticks,
                last_of_run, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/mtep_parser.sv -----
// Byte-serial track grammar state machine producing up to two events per byte.
`default_nettype none

module mtep_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_accept,
   input  wire logic [7:0]        data_byte,
   input  wire logic              end_of_track,
   input  wire mtep_pkg::cfg_type cfg,
   output mtep_pkg::push_type     push
);

   mtep_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]           running_ff, running_in;
   logic [7:0]           current_ff, current_in;
   mtep_pkg::varlen_type acc_ff, acc_in;
   logic [1:0]           cnt_ff, cnt_in;
   mtep_pkg::tick_type   time_ff, time_in;
   mtep_pkg::varlen_type skip_ff, skip_in;
   logic [7:0]           meta_type_ff, meta_type_in;
   mtep_pkg::tempo_type  tempo_ff, tempo_in;
   logic [1:0]           seen_ff, seen_in;
   logic [7:0]           first_ff, first_in;
   logic                 err_ff, err_in;

   mtep_pkg::varlen_type acc_take;
   logic                 take_done;
   mtep_pkg::varlen_type skip_dec;
   logic [3:0]           chan;
   logic                 note_ok;
   logic [3:0]           msg_hi;
   logic                 ev_valid;
   mtep_pkg::result_type ev;
   mtep_pkg::result_type done_ev;

   function automatic mtep_pkg::tempo_type tempo_align(input mtep_pkg::tempo_type value,
                                                       input logic [1:0] bytes_seen);
      mtep_pkg::tempo_type aligned;
      case (bytes_seen)
         2'd3:    aligned = value;
         2'd2:    aligned = {value[15:0], 8'h00};
         2'd1:    aligned = {value[7:0], 16'h0000};
         default: aligned = '0;
      endcase
      return aligned;
   endfunction

   always_comb begin
      phase_in     = phase_ff;
      running_in   = running_ff;
      current_in   = current_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      time_in      = time_ff;
      skip_in      = skip_ff;
      meta_type_in = meta_type_ff;
      tempo_in     = tempo_ff;
      seen_in      = seen_ff;
      first_in     = first_ff;
      err_in       = err_ff;

      acc_take  = {acc_ff[mtep_pkg::VARLEN_BITS-8:0], data_byte[6:0]};
      take_done = !data_byte[7] || (cnt_ff == mtep_pkg::VARLEN_LAST_COUNT);
      skip_dec  = skip_ff - mtep_pkg::varlen_type'(1);
      chan      = current_ff[3:0];
      note_ok   = cfg.channel_enable_mask[chan] && (chan != cfg.percussion_channel);
      msg_hi    = current_ff[7:4];

      ev_valid       = 1'b0;
      ev.event_kind  = mtep_pkg::EV_PLAY;
      ev.note_number = '0;
      ev.level       = '0;
      ev.tempo_value = '0;
      ev.event_ticks = '0;
      ev.last_of_run = 1'b0;

      if (!err_ff) begin
         case (phase_ff)
            mtep_pkg::PH_DELTA: begin
               acc_in = acc_take;
               cnt_in = cnt_ff + 2'd1;
               if (take_done) begin
                  time_in  = time_ff + mtep_pkg::tick_type'(acc_take);
                  acc_in   = '0;
                  cnt_in   = '0;
                  phase_in = mtep_pkg::PH_STATUS;
               end
            end
            mtep_pkg::PH_STATUS: begin
               if (data_byte < mtep_pkg::STATUS_FLAG) begin
                  if (running_ff == '0) begin
                     err_in        = 1'b1;
                     ev_valid      = 1'b1;
                     ev.event_kind = mtep_pkg::EV_ERROR;
                  end else begin
                     current_in = running_ff;
                     if (running_ff[7:4] inside {mtep_pkg::MSG_PROGRAM, mtep_pkg::MSG_PRESSURE})
                     begin
                        phase_in = mtep_pkg::PH_DELTA;
                     end else begin
                        first_in = data_byte;
                        phase_in = mtep_pkg::PH_DATA2;
                     end
                  end
               end else begin
                  current_in = data_byte;
                  acc_in     = '0;
                  cnt_in     = '0;
                  if (data_byte == mtep_pkg::STATUS_META) begin
                     phase_in = mtep_pkg::PH_META_TYPE;
                  end else if (data_byte >= mtep_pkg::STATUS_SYSEX_MIN) begin
                     phase_in = mtep_pkg::PH_SYSEX_LEN;
                  end else begin
                     running_in = data_byte;
                     phase_in   = mtep_pkg::PH_DATA1;
                  end
               end
            end
            mtep_pkg::PH_DATA1: begin
               if (msg_hi inside {mtep_pkg::MSG_PROGRAM, mtep_pkg::MSG_PRESSURE}) begin
                  phase_in = mtep_pkg::PH_DELTA;
               end else begin
                  first_in = data_byte;
                  phase_in = mtep_pkg::PH_DATA2;
               end
            end
            mtep_pkg::PH_DATA2: begin
               ev.level = data_byte;
               case (msg_hi)
                  mtep_pkg::MSG_NOTE_OFF: begin
                     ev_valid       = note_ok;
                     ev.event_kind  = mtep_pkg::EV_STOP;
                     ev.note_number = first_ff;
                  end
                  mtep_pkg::MSG_NOTE_ON: begin
                     ev_valid       = note_ok;
                     ev.event_kind  = (data_byte == '0) ? mtep_pkg::EV_STOP : mtep_pkg::EV_PLAY;
                     ev.note_number = first_ff;
                  end
                  mtep_pkg::MSG_CONTROL: begin
                     if (first_ff == mtep_pkg::CTL_SUSTAIN) begin
                        ev_valid      = 1'b1;
                        ev.event_kind = mtep_pkg::EV_PEDAL0;
                     end else if (first_ff == mtep_pkg::CTL_SOSTENUTO) begin
                        ev_valid      = 1'b1;
                        ev.event_kind = mtep_pkg::EV_PEDAL1;
                     end else if (first_ff == mtep_pkg::CTL_SOFT) begin
                        ev_valid      = 1'b1;
                        ev.event_kind = mtep_pkg::EV_PEDAL2;
                     end
                  end
                  default: begin
                     ev_valid = 1'b0;
                  end
               endcase
               phase_in = mtep_pkg::PH_DELTA;
            end
            mtep_pkg::PH_META_TYPE: begin
               meta_type_in = data_byte;
               acc_in       = '0;
               cnt_in       = '0;
               phase_in     = mtep_pkg::PH_META_LEN;
            end
            mtep_pkg::PH_META_LEN: begin
               acc_in = acc_take;
               cnt_in = cnt_ff + 2'd1;
               if (take_done) begin
                  skip_in  = acc_take;
                  acc_in   = '0;
                  cnt_in   = '0;
                  tempo_in = '0;
                  seen_in  = '0;
                  if (acc_take == '0) begin
                     ev_valid      = (meta_type_ff == mtep_pkg::META_TEMPO);
                     ev.event_kind = mtep_pkg::EV_TEMPO;
                     phase_in      = mtep_pkg::PH_DELTA;
                  end else begin
                     phase_in = mtep_pkg::PH_META_DATA;
                  end
               end
            end
            mtep_pkg::PH_META_DATA: begin
               if ((meta_type_ff == mtep_pkg::META_TEMPO) &&
                   (seen_ff != mtep_pkg::TEMPO_FULL_BYTES)) begin
                  tempo_in = {tempo_ff[mtep_pkg::TEMPO_BITS-9:0], data_byte};
                  seen_in  = seen_ff + 2'd1;
               end
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  ev_valid       = (meta_type_ff == mtep_pkg::META_TEMPO);
                  ev.event_kind  = mtep_pkg::EV_TEMPO;
                  ev.tempo_value = tempo_align(tempo_in, seen_in);
                  phase_in       = mtep_pkg::PH_DELTA;
               end
            end
            mtep_pkg::PH_SYSEX_LEN: begin
               acc_in = acc_take;
               cnt_in = cnt_ff + 2'd1;
               if (take_done) begin
                  skip_in  = acc_take;
                  acc_in   = '0;
                  cnt_in   = '0;
                  phase_in = (acc_take == '0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
               end
            end
            mtep_pkg::PH_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = mtep_pkg::PH_DELTA;
               end
            end
            default: begin
               phase_in = mtep_pkg::PH_DELTA;
            end
         endcase
      end

      ev.event_ticks = mtep_pkg::event_ticks_type'(time_in);

      done_ev             = '0;
      done_ev.event_kind  = mtep_pkg::EV_DONE;
      done_ev.event_ticks = mtep_pkg::event_ticks_type'(time_in);
      done_ev.last_of_run = 1'b1;

      push.count  = 2'd0;
      push.first  = ev;
      push.second = done_ev;
      if (in_accept) begin
         if (ev_valid && end_of_track) begin
            push.count = 2'd2;
         end else if (ev_valid) begin
            push.count             = 2'd1;
            push.first.last_of_run = 1'b1;
         end else if (end_of_track) begin
            push.count = 2'd1;
            push.first = done_ev;
         end
      end

      if (end_of_track) begin
         phase_in     = mtep_pkg::PH_DELTA;
         running_in   = '0;
         current_in   = '0;
         acc_in       = '0;
         cnt_in       = '0;
         time_in      = '0;
         skip_in      = '0;
         meta_type_in = '0;
         tempo_in     = '0;
         seen_in      = '0;
         first_in     = '0;
         err_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= mtep_pkg::PH_DELTA;
         running_ff   <= '0;
         current_ff   <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         time_ff      <= '0;
         skip_ff      <= '0;
         meta_type_ff <= '0;
         tempo_ff     <= '0;
         seen_ff      <= '0;
         first_ff     <= '0;
         err_ff       <= 1'b0;
      end else if (in_accept) begin
         phase_ff     <= phase_in;
         running_ff   <= running_in;
         current_ff   <= current_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         time_ff      <= time_in;
         skip_ff      <= skip_in;
         meta_type_ff <= meta_type_in;
         tempo_ff     <= tempo_in;
         seen_ff      <= seen_in;
         first_ff     <= first_in;
         err_ff       <= err_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/mtep_rsp_fifo.sv -----
// Result queue taking up to two events per cycle and releasing one per transaction.
`default_nettype none

module mtep_rsp_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mtep_pkg::push_type push,
   output logic                    space_ok,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output mtep_pkg::result_type    out_data
);

   mtep_pkg::result_type                  mem_ff [mtep_pkg::RSP_DEPTH];
   logic [mtep_pkg::RSP_PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [mtep_pkg::RSP_PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [mtep_pkg::RSP_CNT_BITS-1:0]     count_ff, count_in;
   logic [mtep_pkg::RSP_PTR_BITS-1:0]     wr_next;
   logic                                  pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign space_ok  = (count_ff <= mtep_pkg::RSP_CNT_BITS'(mtep_pkg::RSP_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + mtep_pkg::RSP_PTR_BITS'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + mtep_pkg::RSP_PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + mtep_pkg::RSP_PTR_BITS'(pop);
      count_in  = count_ff + mtep_pkg::RSP_CNT_BITS'(push.count)
                  - mtep_pkg::RSP_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/midi_track_event_parser.sv -----
// Top level of the MIDI track event parser with its configuration registers.
// The block takes the bytes of one MIDI track chunk on the request channel, one byte per
// transaction with an end_of_track flag on the final byte, and returns play, stop, tempo,
// pedal, track-done and error events on the response channel, each stamped with the track
// time in ticks.
// Each byte is parsed in the cycle it is accepted and its events are written into a
// four-entry result queue, so an event appears on the response channel only after it has
// been registered in the queue. A byte may cause up to two events; the second follows the
// first in the queue.
// One byte is accepted every cycle while the queue has room for two events, so the
// sustained rate is one byte per cycle when the receiver takes one event per cycle.
// When the receiver stalls, the queue fills and the request channel's ready falls until
// entries are taken; nothing is lost.
// A synchronous reset clears the parser state and empties the queue, and sets the channel
// enable mask to all ones and the percussion channel to nine. The user must write the
// configuration registers through the csr port only while the block is idle; the block
// does not enforce this. End of track clears the parser state but keeps those registers.
`default_nettype none

module midi_track_event_parser (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   mtep_req_if.sink                                  req_bus,
   mtep_rsp_if.source                                rsp_bus,
   input  wire logic                                 csr_write_enable,
   input  wire logic                                 csr_index,
   input  wire logic [mtep_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   mtep_pkg::cfg_type    cfg_ff, cfg_in;
   mtep_pkg::push_type   push;
   mtep_pkg::result_type head;
   logic                 space_ok;
   logic                 in_accept;

   assign req_bus.ready = space_ok;
   assign in_accept     = req_bus.valid && space_ok;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (mtep_pkg::csr_reg_type'(csr_index))
            mtep_pkg::REG_CHANNEL_MASK: cfg_in.channel_enable_mask = csr_write_data;
            mtep_pkg::REG_PERCUSSION:   cfg_in.percussion_channel  = csr_write_data[3:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_enable_mask <= 16'hffff;
         cfg_ff.percussion_channel  <= 4'd9;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mtep_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .in_accept    (in_accept),
      .data_byte    (req_bus.data_byte),
      .end_of_track (req_bus.end_of_track),
      .cfg          (cfg_ff),
      .push         (push)
   );

   mtep_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (head)
   );

   assign rsp_bus.event_kind  = head.event_kind;
   assign rsp_bus.note_number = head.note_number;
   assign rsp_bus.level       = head.level;
   assign rsp_bus.tempo_value = head.tempo_value;
   assign rsp_bus.event_ticks = head.event_ticks;
   assign rsp_bus.last_of_run = head.last_of_run;

endmodule

`default_nettype wire

// ----- rtl/core/mtep_checker.sv -----
// Port-level checker for the MIDI track event parser and its bind statement.
`default_nettype none

module mtep_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_end_of_track,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_event_kind,
   input wire logic [31:0] rsp_event_ticks,
   input wire logic        rsp_last_of_run
);

   a_empty_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind)
                                  && $stable(rsp_event_ticks))
      else $error("stalled response transaction changed");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == mtep_pkg::EV_DONE) |-> rsp_last_of_run)
      else $error("track done event not marked last");

   a_track_end_answers: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end_of_track |=> rsp_valid)
      else $error("no response after the final track byte");

   a_pair_completes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=>
         rsp_valid && (rsp_event_kind == mtep_pkg::EV_DONE))
      else $error("first event of a pair not followed by track done");

endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_end_of_track (req_bus.end_of_track),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_event_kind   (rsp_bus.event_kind),
   .rsp_event_ticks  (rsp_bus.event_ticks),
   .rsp_last_of_run  (rsp_bus.last_of_run)
);

`default_nettype wire
